/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk_s, rst_n, a, c) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk_s, rst_n, a, c) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk_s, rst_n, a, c)
`define ASSERT_NEXT(label, clk_s, rst_n, a, c)
`endif
`endif

/* rtl/hmbp_pkg.sv */
// ----------------------------------------------------------------------------
// hmbp_pkg
// Shared types and constants of the HTTP message byte parser.
// ----------------------------------------------------------------------------
package hmbp_pkg;
	localparam int DefLengthWidth = 32;
	localparam int QueueDepth = 2;

	// Field classes.
	localparam logic [3:0] CLS_DELIM   = 4'd0;
	localparam logic [3:0] CLS_VERSION = 4'd3;
	localparam logic [3:0] CLS_STATUS  = 4'd4;
	localparam logic [3:0] CLS_HNAME   = 4'd5;
	localparam logic [3:0] CLS_HVALUE  = 4'd6;
	localparam logic [3:0] CLS_BODY    = 4'd7;
	localparam logic [3:0] CLS_DISCARD = 4'd8;

	// Error codes.
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_SYMBOL = 3'd1;
	localparam logic [2:0] ERR_NAME   = 3'd2;
	localparam logic [2:0] ERR_STATUS = 3'd3;
	localparam logic [2:0] ERR_LENGTH = 3'd4;

	// Byte kinds found by the front part.
	typedef enum logic [2:0] {
		BK_OTHER, BK_SPACE, BK_CR, BK_LF, BK_COLON, BK_DIGIT, BK_TAB
	} byte_kind_t;

	// Classified item passed from front to back.
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] lower;
		byte_kind_t kind;
		logic       abort;
	} item_t;

	localparam int ItemWidth = $bits(item_t);

	// Status text byte at a position, for each candidate.
	function automatic logic [7:0] status_char(input logic [1:0] c, input logic [4:0] p);
		logic [8*25-1:0] s;
		logic [4:0] n;
		unique case (c)
			2'd0: begin s = {"200 OK", 152'd0}; n = 5'd6; end
			2'd1: begin s = {"200 Ok", 152'd0}; n = 5'd6; end
			2'd2: begin s = {"404 Not Found", 96'd0}; n = 5'd13; end
			default: begin s = "500 Internal Server Error"; n = 5'd25; end
		endcase
		if (p < n) status_char = s[8*(24-p) +: 8];
		else status_char = 8'h00;
	endfunction

	function automatic logic [4:0] status_len(input logic [1:0] c);
		unique case (c)
			2'd0, 2'd1: status_len = 5'd6;
			2'd2: status_len = 5'd13;
			default: status_len = 5'd25;
		endcase
	endfunction

	function automatic logic [7:0] cl_char(input logic [3:0] p);
		logic [8*14-1:0] s;
		s = "content-length";
		if (p < 4'd14) cl_char = s[8*(13-p) +: 8];
		else cl_char = 8'hff;
	endfunction
endpackage

/* rtl/hmbp_front.sv */
// ----------------------------------------------------------------------------
// hmbp_front
// Accepts stream bytes and classifies them into an item for the back part.
// ----------------------------------------------------------------------------
module hmbp_front import hmbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_data,
	input  logic       in_abort,
	input  logic       in_valid,
	output logic       in_ready,
	output item_t      itm,
	output logic       itm_valid,
	input  logic       itm_ready
);
	logic  valid_q;
	item_t item_q;
	byte_kind_t k;
	logic [7:0] lw;

	// Byte classification and lower-casing.
	always_comb begin
		lw = in_data;
		if (in_data >= "A" && in_data <= "Z") lw = in_data + 8'd32;
		priority if (in_data == " ") k = BK_SPACE;
		else if (in_data == 8'h0d) k = BK_CR;
		else if (in_data == 8'h0a) k = BK_LF;
		else if (in_data == ":") k = BK_COLON;
		else if (in_data >= "0" && in_data <= "9") k = BK_DIGIT;
		else if (in_data == 8'h09) k = BK_TAB;
		else k = BK_OTHER;
	end

	assign in_ready = !valid_q || itm_ready;
	assign itm = item_q;
	assign itm_valid = valid_q;

	// Registered stage toward the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= '{data: in_data, lower: lw, kind: k, abort: in_abort};
		end
	end
endmodule

/* rtl/hmbp_queue.sv */
// ----------------------------------------------------------------------------
// hmbp_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module hmbp_queue import hmbp_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t wr_item,
	input  logic  wr_valid,
	output logic  wr_ready,
	output item_t rd_item,
	output logic  rd_valid,
	input  logic  rd_ready
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	item_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = cnt_q != Depth[AW:0];
	assign rd_valid = cnt_q != '0;
	assign rd_item = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_item;
	end
endmodule

/* rtl/hmbp_back.sv */
// ----------------------------------------------------------------------------
// hmbp_back
// Parser FSM; one classified byte per cycle into a result register when not stalled.
// ----------------------------------------------------------------------------
module hmbp_back import hmbp_pkg::*; #(
	parameter int LengthWidth = DefLengthWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        kind_rsp,
	input  item_t       itm,
	input  logic        itm_valid,
	output logic        itm_ready,
	output logic [7:0]  o_byte,
	output logic [3:0]  o_class,
	output logic        o_end,
	output logic [1:0]  o_status,
	output logic [31:0] o_length,
	output logic        o_done,
	output logic [2:0]  o_error,
	output logic        o_valid,
	input  logic        o_ready
);
	typedef enum logic [2:0] {PH_WORD, PH_STATUS, PH_HEADER, PH_BLANK, PH_BODY} phase_t;
	localparam logic [LengthWidth-1:0] LenMax = '1;
	localparam logic [LengthWidth-1:0] LenLimit = LenMax / 10;
	localparam logic [3:0] LenDigitLimit = 4'(LenMax % 10);

	phase_t phase_q, ph;
	logic [1:0] widx_q, wi;
	logic in_name_q, inn, nonempty_q, ne, skip_q, sk, elf_q, el;
	logic [3:0] clpos_q, cp;
	logic clm_q, cm, digit_q, dg;
	logic [4:0] spos_q, sp;
	logic [3:0] cand_q, cd;
	logic [LengthWidth-1:0] acc_q, ac, body_q, bd;
	logic [LengthWidth-1:0] ao;
	logic [2:0] err_q, er;
	logic [7:0] ob, b;
	logic [3:0] cls, dval;
	logic fend, done;
	logic [1:0] sc;
	logic fire;

	assign itm_ready = !o_valid || o_ready;
	assign fire = itm_valid && itm_ready;
	assign b = itm.data;
	assign dval = 4'(itm.data - "0");

	// Next-state logic for one byte.
	always_comb begin
		ph = phase_q; wi = widx_q; inn = in_name_q; ne = nonempty_q; sk = skip_q;
		el = elf_q; cp = clpos_q; cm = clm_q; dg = digit_q; sp = spos_q; cd = cand_q;
		ac = acc_q; bd = body_q; er = err_q;
		ob = b; cls = CLS_DELIM; fend = 1'b0; sc = 2'd0; done = 1'b0;
		if (itm.abort) begin
			er = ERR_NONE; cls = CLS_DISCARD;
			ph = PH_WORD; wi = '0; el = 1'b0; sp = '0; cd = 4'hf; ac = '0; bd = '0;
			inn = 1'b1; ne = 1'b0; sk = 1'b0; cp = '0; cm = 1'b1; dg = 1'b0;
		end else if (err_q != ERR_NONE) begin
			cls = CLS_DISCARD;
		end else if (elf_q) begin
			el = 1'b0;
			if (itm.kind != BK_LF) begin
				er = ERR_SYMBOL;
			end else begin
				unique case (phase_q)
					PH_WORD: begin
						wi = widx_q + 2'd1;
						if (kind_rsp) ph = PH_STATUS;
						else if (wi == 2'd3) begin
							ph = PH_HEADER;
							inn = 1'b1; ne = 1'b0; sk = 1'b0; cp = '0; cm = 1'b1; dg = 1'b0;
						end
					end
					PH_STATUS: begin
						priority if (cand_q[0] && spos_q == status_len(2'd0)) sc = 2'd1;
						else if (cand_q[1] && spos_q == status_len(2'd1)) sc = 2'd1;
						else if (cand_q[2] && spos_q == status_len(2'd2)) sc = 2'd2;
						else if (cand_q[3] && spos_q == status_len(2'd3)) sc = 2'd3;
						else sc = 2'd0;
						if (sc == 2'd0) er = ERR_STATUS;
						else begin
							ph = PH_HEADER;
							inn = 1'b1; ne = 1'b0; sk = 1'b0; cp = '0; cm = 1'b1; dg = 1'b0;
						end
					end
					PH_HEADER: begin
						if (clpos_q == 4'd14 && !digit_q) er = ERR_LENGTH;
						else begin
							inn = 1'b1; ne = 1'b0; sk = 1'b0; cp = '0; cm = 1'b1; dg = 1'b0;
						end
					end
					PH_BLANK: begin
						bd = acc_q;
						if (acc_q == '0) done = 1'b1;
						else ph = PH_BODY;
					end
					default: cls = CLS_DISCARD;
				endcase
			end
		end else begin
			unique case (phase_q)
				PH_WORD: begin
					if (itm.kind == BK_SPACE) begin
						fend = 1'b1;
						wi = widx_q + 2'd1;
						if (kind_rsp) ph = PH_STATUS;
						else if (wi == 2'd3) begin
							ph = PH_HEADER;
							inn = 1'b1; ne = 1'b0; sk = 1'b0; cp = '0; cm = 1'b1; dg = 1'b0;
						end
					end else if (itm.kind == BK_CR) begin
						fend = 1'b1; el = 1'b1;
					end else begin
						cls = kind_rsp ? CLS_VERSION : {2'b00, widx_q} + 4'd1;
					end
				end
				PH_STATUS: begin
					if (itm.kind == BK_CR) begin
						fend = 1'b1; el = 1'b1;
					end else begin
						cls = CLS_STATUS;
						for (int i = 0; i < 4; i++) begin
							if (!(spos_q < status_len(2'(i)) && status_char(2'(i), spos_q) == b))
								cd[i] = 1'b0;
						end
						if (spos_q < 5'd31) sp = spos_q + 5'd1;
					end
				end
				PH_HEADER: begin
					sk = 1'b0;
					if (skip_q && itm.kind == BK_SPACE) begin
						cls = CLS_DELIM;
					end else if (itm.kind == BK_CR) begin
						if (in_name_q && !nonempty_q) ph = PH_BLANK;
						else fend = 1'b1;
						el = 1'b1;
					end else if (in_name_q) begin
						if (itm.kind == BK_COLON) begin
							if (!nonempty_q) er = ERR_NAME;
							else begin
								inn = 1'b0; fend = 1'b1; sk = 1'b1;
								if (clpos_q == 4'd14) begin
									ac = '0; cm = 1'b1;
								end
							end
						end else begin
							ob = itm.lower; cls = CLS_HNAME; ne = 1'b1;
							if (clm_q && clpos_q < 4'd14 && itm.lower == cl_char(clpos_q))
								cp = clpos_q + 4'd1;
							else begin
								cm = 1'b0; cp = 4'd15;
							end
						end
					end else begin
						cls = CLS_HVALUE;
						if (clpos_q == 4'd14 && clm_q) begin
							if (itm.kind == BK_DIGIT) begin
								if (acc_q > LenLimit || (acc_q == LenLimit && dval > LenDigitLimit))
									ac = LenMax;
								else
									ac = LengthWidth'(acc_q * 10) + LengthWidth'(dval);
								dg = 1'b1;
							end else if (!((itm.kind == BK_SPACE || itm.kind == BK_TAB)
									&& !digit_q)) begin
								cm = 1'b0;
							end
						end
					end
				end
				PH_BODY: begin
					cls = CLS_BODY;
					if (body_q != '0) bd = body_q - 1'b1;
					if (bd == '0) done = 1'b1;
				end
				default: cls = CLS_DISCARD;
			endcase
		end
		if (er != ERR_NONE) begin
			cls = CLS_DISCARD; fend = 1'b0; sc = 2'd0; done = 1'b0;
		end
		// The reported length is the accumulator after this byte, before completion clears it.
		ao = ac;
		if (done) begin
			ph = PH_WORD; wi = '0; el = 1'b0; sp = '0; cd = 4'hf; ac = '0; bd = '0;
			inn = 1'b1; ne = 1'b0; sk = 1'b0; cp = '0; cm = 1'b1; dg = 1'b0;
		end
	end

	// Parser state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WORD; widx_q <= '0; in_name_q <= 1'b1; nonempty_q <= 1'b0;
			skip_q <= 1'b0; elf_q <= 1'b0; clpos_q <= '0; clm_q <= 1'b1; digit_q <= 1'b0;
			spos_q <= '0; cand_q <= 4'hf; acc_q <= '0; body_q <= '0; err_q <= ERR_NONE;
			o_valid <= 1'b0;
		end else begin
			if (itm_ready) o_valid <= itm_valid;
			if (fire) begin
				phase_q <= ph; widx_q <= wi; in_name_q <= inn; nonempty_q <= ne;
				skip_q <= sk; elf_q <= el; clpos_q <= cp; clm_q <= cm; digit_q <= dg;
				spos_q <= sp; cand_q <= cd; acc_q <= ac; body_q <= bd; err_q <= er;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			o_byte <= ob; o_class <= cls; o_end <= fend; o_status <= sc; o_done <= done;
			o_error <= er;
			if (LengthWidth > 32 && (ao >> 32) != '0) o_length <= '1;
			else o_length <= 32'(ao);
		end
	end
endmodule

/* rtl/http_message_byte_parser_top.sv */
// ----------------------------------------------------------------------------
// http_message_byte_parser_top
// Streaming HTTP/1.x parser, one byte per transaction, with APB config.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_axis   in         tdata = in_byte, tuser = abort
// m_axis   out        tdata = out_byte, status/len/etc; tuser = field_class
// apb      in         register 0: message_kind
// One byte per cycle unless the output stalls; a byte passes the front
// register, queue and result register. The parser state update in the back
// part is the loop that sets this rate. Reset clears all control state; no
// clearing pass. Either side may stall on its own through the item queue.
`include "assert_macros.svh"
module http_message_byte_parser_top import hmbp_pkg::*; #(
	parameter int LengthWidth = DefLengthWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tuser,  // [0] abort
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte, [8] field_end, [10:9] status_code, [42:11] content_length,
	// [43] message_done, [46:44] error_code, [47] zero
	output logic [47:0] m_axis_tdata,
	output logic [3:0]  m_axis_tuser,  // [3:0] field_class
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam logic [1:0] RegKind = 2'd0;
	logic kind_q;
	item_t f_item, q_item;
	logic f_valid, f_ready, q_valid, q_ready;
	logic [7:0] ob;
	logic [3:0] cls;
	logic fe, dn;
	logic [1:0] sc;
	logic [31:0] len;
	logic [2:0] er;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == RegKind) ? {31'd0, kind_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == RegKind) begin
			kind_q <= pwdata[0];
		end
	end

	hmbp_front u_front (
		.clk, .arst_n, .in_data(s_axis_tdata), .in_abort(s_axis_tuser),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.itm(f_item), .itm_valid(f_valid), .itm_ready(f_ready)
	);

	hmbp_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr_item(f_item), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_item(q_item), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	hmbp_back #(.LengthWidth(LengthWidth)) u_back (
		.clk, .arst_n, .kind_rsp(kind_q), .itm(q_item), .itm_valid(q_valid),
		.itm_ready(q_ready), .o_byte(ob), .o_class(cls), .o_end(fe), .o_status(sc),
		.o_length(len), .o_done(dn), .o_error(er), .o_valid(m_axis_tvalid),
		.o_ready(m_axis_tready)
	);

	assign m_axis_tdata = {1'b0, er, dn, len, sc, fe, ob};
	assign m_axis_tuser = cls;

	// A raised error forces the discarded class.
	`ASSERT_IMPLIES(a_err_discard, clk, arst_n, m_axis_tvalid && er != ERR_NONE,
		cls == CLS_DISCARD)
	// Completion and status never coincide with an error.
	`ASSERT_IMPLIES(a_done_clean, clk, arst_n, m_axis_tvalid && (dn || sc != 2'd0),
		er == ERR_NONE)
	// A stalled result holds.
	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
endmodule

/* verif/http_message_byte_parser_top_tb.sv */
// ----------------------------------------------------------------------------
// http_message_byte_parser_top_tb
// Self-checking bench for the HTTP message byte parser. A behavioral parser
// model predicts every tagged output byte. A checker compares each output
// transaction field by field against the oldest prediction. Directed request,
// response and error messages come first, then random well-formed messages
// mixed with noise, aborts and broken lines.
// ----------------------------------------------------------------------------
module http_message_byte_parser_top_tb;
	import hmbp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] CLS_METHOD = 4'd1;
	localparam logic [3:0] CLS_TARGET = 4'd2;
	localparam logic [1:0] SC_NONE = 2'd0;
	localparam logic [1:0] ADDR_KIND = 2'd0;
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_RESPONSE = 1'b1;
	localparam int WatchdogLimit = 5000;
	localparam int RandomItems = 180;
	localparam int Latency = 8;

	typedef enum logic [2:0] {
		PH_WORD, PH_STATUS, PH_HEADER, PH_BLANK, PH_BODY
	} phase_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [3:0]  cls;
		logic        fend;
		logic [1:0]  sc;
		logic [31:0] len;
		logic        done;
		logic [2:0]  err;
	} tagged_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;  // [7:0] in_byte
	logic        s_axis_tuser = 1'b0;  // [0] abort
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] out_byte, [8] field_end, [10:9] status_code, [42:11] content_length,
	// [43] message_done, [46:44] error_code, [47] zero
	logic [47:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;  // [3:0] field_class
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	http_message_byte_parser_top u_top (.*);

	always #10 clk = ~clk;

	// Parser model state.
	logic        kind_reg = KIND_REQUEST;
	phase_t      phase;
	logic [1:0]  word_idx;
	logic        in_name, name_seen, skip_space, want_lf;
	logic [3:0]  cl_pos;
	logic        cl_ok;
	logic [4:0]  st_pos;
	logic [3:0]  st_live;
	logic [31:0] len_acc;
	logic        digit_seen;
	logic [31:0] body_left;
	logic [2:0]  err = ERR_NONE;

	string st_txt[4] = '{"200 OK", "200 Ok", "404 Not Found", "500 Internal Server Error"};
	logic [1:0] st_code[4] = '{2'd1, 2'd1, 2'd2, 2'd3};
	string cl_str = "content-length";

	tagged_byte_t expected_bytes[$];
	int errors = 0;
	bit quiet = 1'b0;
	int sent = 0;

	function automatic void start_line_fields();
		in_name = 1'b1;
		name_seen = 1'b0;
		skip_space = 1'b0;
		cl_pos = 4'd0;
		cl_ok = 1'b1;
		digit_seen = 1'b0;
	endfunction

	function automatic void restart_message();
		phase = PH_WORD;
		word_idx = 2'd0;
		want_lf = 1'b0;
		st_pos = 5'd0;
		st_live = 4'hF;
		len_acc = '0;
		body_left = '0;
		start_line_fields();
	endfunction

	function automatic void advance_word();
		word_idx = word_idx + 2'd1;
		if (kind_reg == KIND_RESPONSE) begin
			phase = PH_STATUS;
		end else if (word_idx == 2'd3) begin
			phase = PH_HEADER;
			start_line_fields();
		end
	endfunction

	// Works out the tagged output for one accepted input byte.
	function automatic tagged_byte_t parse_byte(logic [7:0] b, logic ab);
		tagged_byte_t r;
		logic [7:0] ob;
		logic [3:0] cls;
		logic fend, done;
		logic [1:0] sc;
		logic [63:0] d;
		ob = b;
		cls = CLS_DELIM;
		fend = 1'b0;
		sc = SC_NONE;
		done = 1'b0;
		if (ab) begin
			err = ERR_NONE;
			restart_message();
			cls = CLS_DISCARD;
		end else if (err != ERR_NONE) begin
			cls = CLS_DISCARD;
		end else if (want_lf) begin
			want_lf = 1'b0;
			if (b != 8'h0A) begin
				err = ERR_SYMBOL;
			end else begin
				case (phase)
					PH_WORD: advance_word();
					PH_STATUS: begin
						for (int i = 0; i < 4; i++)
							if (sc == SC_NONE && st_live[i] && st_pos == st_txt[i].len())
								sc = st_code[i];
						if (sc == SC_NONE) err = ERR_STATUS;
						else begin
							phase = PH_HEADER;
							start_line_fields();
						end
					end
					PH_HEADER: begin
						if (cl_pos == 4'd14 && !digit_seen) err = ERR_LENGTH;
						else start_line_fields();
					end
					PH_BLANK: begin
						body_left = len_acc;
						if (body_left == 0) done = 1'b1;
						else phase = PH_BODY;
					end
					default: cls = CLS_DISCARD;
				endcase
			end
		end else if (phase == PH_WORD) begin
			if (b == " ") begin
				fend = 1'b1;
				advance_word();
			end else if (b == 8'h0D) begin
				fend = 1'b1;
				want_lf = 1'b1;
			end else begin
				cls = (kind_reg == KIND_RESPONSE) ? CLS_VERSION : {2'b00, word_idx} + 4'd1;
			end
		end else if (phase == PH_STATUS) begin
			if (b == 8'h0D) begin
				fend = 1'b1;
				want_lf = 1'b1;
			end else begin
				cls = CLS_STATUS;
				for (int i = 0; i < 4; i++)
					if (!(st_pos < st_txt[i].len() && st_txt[i][st_pos] == b))
						st_live[i] = 1'b0;
				if (st_pos < 5'd31) st_pos++;
			end
		end else if (phase == PH_HEADER) begin
			if (skip_space && b == " ") begin
				skip_space = 1'b0;
			end else begin
				skip_space = 1'b0;
				if (b == 8'h0D) begin
					if (in_name && !name_seen) phase = PH_BLANK;
					else fend = 1'b1;
					want_lf = 1'b1;
				end else if (in_name) begin
					if (b == ":") begin
						if (!name_seen) err = ERR_NAME;
						else begin
							in_name = 1'b0;
							fend = 1'b1;
							skip_space = 1'b1;
							if (cl_pos == 4'd14) begin
								len_acc = '0;
								cl_ok = 1'b1;
							end
						end
					end else begin
						if (b >= "A" && b <= "Z") ob = b + 8'd32;
						cls = CLS_HNAME;
						name_seen = 1'b1;
						if (cl_ok && cl_pos < 4'd14 && ob == cl_str[cl_pos]) begin
							cl_pos++;
						end else begin
							cl_ok = 1'b0;
							cl_pos = 4'd15;
						end
					end
				end else begin
					cls = CLS_HVALUE;
					if (cl_pos == 4'd14 && cl_ok) begin
						if (b >= "0" && b <= "9") begin
							d = 64'(b - "0");
							if (64'(len_acc) > (64'hFFFF_FFFF - d) / 10) len_acc = '1;
							else len_acc = 32'(64'(len_acc) * 10 + d);
							digit_seen = 1'b1;
						end else if (!((b == " " || b == 8'h09) && !digit_seen)) begin
							cl_ok = 1'b0;
						end
					end
				end
			end
		end else if (phase == PH_BODY) begin
			cls = CLS_BODY;
			if (body_left > 0) body_left--;
			if (body_left == 0) done = 1'b1;
		end else begin
			cls = CLS_DISCARD;
		end
		if (err != ERR_NONE) begin
			cls = CLS_DISCARD;
			fend = 1'b0;
			sc = SC_NONE;
			done = 1'b0;
		end
		r = '{data: ob, cls: cls, fend: fend, sc: sc, len: len_acc, done: done, err: err};
		if (done) restart_message();
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Output side: random stall bursts, result checking and the watchdog.
	int stall_left = 0;
	int idle_cycles = 0;
	always @(posedge clk) begin
		tagged_byte_t w;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				$display("unexpected output transaction at %0t", $realtime);
				errors++;
			end else begin
				w = expected_bytes.pop_front();
				if (m_axis_tdata[7:0] !== w.data) report_mismatch("out_byte", m_axis_tdata[7:0], w.data);
				if (m_axis_tuser !== w.cls) report_mismatch("field_class", m_axis_tuser, w.cls);
				if (m_axis_tdata[8] !== w.fend) report_mismatch("field_end", m_axis_tdata[8], w.fend);
				if (m_axis_tdata[10:9] !== w.sc) report_mismatch("status_code", m_axis_tdata[10:9], w.sc);
				if (m_axis_tdata[42:11] !== w.len)
					report_mismatch("content_length", m_axis_tdata[42:11], w.len);
				if (m_axis_tdata[43] !== w.done) report_mismatch("message_done", m_axis_tdata[43], w.done);
				if (m_axis_tdata[46:44] !== w.err) report_mismatch("error_code", m_axis_tdata[46:44], w.err);
			end
		end
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sends one byte transaction, with an occasional gap before it.
	task automatic send_byte(logic [7:0] b, logic ab = 1'b0);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= ab;
		do @(posedge clk); while (!s_axis_tready);
		expected_bytes.push_back(parse_byte(b, ab));
		if (!ab) sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// Stops sending and waits until every predicted byte has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	task automatic write_kind(logic v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_KIND;
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		kind_reg = v;
	endtask

	function automatic string mix_case(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
		return r;
	endfunction

	function automatic string rand_word(int lo, int hi);
		string r;
		string pool;
		int k;
		pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/.-_";
		r = "";
		repeat ($urandom_range(lo, hi)) begin
			k = $urandom_range(0, pool.len() - 1);
			r = {r, pool.substr(k, k)};
		end
		return r;
	endfunction

	// Headers, blank line and body of one well-formed message.
	task automatic send_headers_and_body();
		int n;
		n = $urandom_range(0, 6);
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 2) == 0) begin
				send_text(mix_case("content-type"));
				send_text(": ");
				send_text(rand_word(1, 8));
			end else begin
				send_text(rand_word(1, 8));
				if ($urandom_range(0, 1)) send_text(": ");
				else send_text(":");
				send_text(rand_word(0, 8));
			end
			send_text("\r\n");
		end
		if (n > 0 || $urandom_range(0, 1)) begin
			send_text({mix_case("content-length"), ":"});
			if ($urandom_range(0, 1)) send_text(" \t");
			else send_text(" ");
			send_text({$sformatf("%0d", n), "\r\n"});
		end
		send_text("\r\n");
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// Garbage bytes and broken lines, then an abort to recover.
	task automatic send_noise();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 3))
				0: send_byte(8'h0D);
				1: send_byte(":");
				2: send_byte(8'h0A);
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic test_directed_request();
		write_kind(KIND_REQUEST);
		send_text("GET / HTTP/1.1\r\nHOST:  x\r\nContent-Length: 3\r\nA\r\n\r\n");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		// Words closed by line ends, then a blank line right after the start line.
		send_text("M\r\nT\r\nV\r\n\r\n");
		// Sender holds off until everything is back before the next phase.
		drain();
	endtask

	task automatic test_directed_response();
		write_kind(KIND_RESPONSE);
		send_text("HTTP/1.1 200 OK\r\n\r\n");
		send_text("H 404 Not Found\r\ncontent-length:99999999999x\r\n\r\n");
		send_byte(8'h5A, 1'b1);
		send_text("H 500 Internal Server Error\r\n\r\nH 200 Ok\r\n\r\n");
		send_text("H 302 Found\r\n");
		send_byte(8'h00, 1'b1);
		drain();
	endtask

	task automatic test_directed_errors();
		write_kind(KIND_REQUEST);
		send_text("A B C\rX");
		send_byte(8'h00, 1'b1);
		send_text("A B C\r\n:v");
		send_byte(8'h00, 1'b1);
		send_text("A B C\r\nContent-length: x\r\n");
		send_byte(8'h00, 1'b1);
		drain();
	endtask

	task automatic run_random(logic kind, int goal);
		drain();
		write_kind(kind);
		while (sent < goal) begin
			if (err != ERR_NONE || phase != PH_WORD || word_idx != 2'd0 || want_lf)
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			case ($urandom_range(0, 9))
				0: send_noise();
				1: begin
					send_text({rand_word(1, 5), " ", rand_word(1, 6)});
					send_byte(8'($urandom_range(0, 255)), 1'b1);
				end
				default: begin
					if (kind == KIND_RESPONSE) begin
						send_text({"HTTP/1.", rand_word(1, 1), " "});
						send_text($urandom_range(0, 7) == 0 ? rand_word(3, 9)
							: st_txt[$urandom_range(0, 3)]);
						send_text("\r\n");
					end else begin
						send_text({rand_word(1, 6), " ", rand_word(1, 8), " ", rand_word(1, 8), "\r\n"});
					end
					send_headers_and_body();
				end
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		restart_message();
		@(posedge clk);
		test_directed_request();
		test_directed_response();
		test_directed_errors();
		run_random(KIND_REQUEST, sent + RandomItems / 3);
		run_random(KIND_RESPONSE, sent + RandomItems / 3);
		quiet = 1'b1;
		run_random(KIND_REQUEST, sent + RandomItems / 3);
		drain();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
